// File: rtl/lhr_pkg.sv
// ----------------------------------------------------------------------------
// lhr_pkg
// Types and constants shared by the LIN header regenerating repeater.
// ----------------------------------------------------------------------------
package lhr_pkg;

    localparam int FRAME_BUF_BYTES = 20;
    localparam logic [4:0] FRAME_LIMIT =
        5'((FRAME_BUF_BYTES < 31) ? FRAME_BUF_BYTES : 31);

    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [3:0] STRAY_SAT = 4'hF;
    localparam logic [4:0] HEADER_BYTES = 5'd2;

    // Configuration register reset values.
    localparam logic [3:0]  RST_SYNC_MAX   = 4'd3;
    localparam logic [15:0] RST_SYNC_WIN   = 16'd600;
    localparam logic [15:0] RST_BREAK_LEN  = 16'd1500;

    typedef enum logic [2:0] {
        REG_SYNC_MAX     = 3'd0,
        REG_SYNC_WINDOW  = 3'd1,
        REG_BREAK_LEN    = 3'd2,
        REG_MASTER_READY = 3'd3,
        REG_SLAVE_READY  = 3'd4
    } t_reg_index;

    typedef enum logic [2:0] {
        CMD_MASTER_BYTE  = 3'd0,
        CMD_MASTER_BREAK = 3'd1,
        CMD_OVERFLOW     = 3'd2,
        CMD_FRAME_END    = 3'd3,
        CMD_SLAVE_BYTE   = 3'd4
    } t_command;

    typedef enum logic [2:0] {
        ACT_SEND_BREAK   = 3'd0,
        ACT_TO_SLAVE     = 3'd1,
        ACT_TO_MASTER    = 3'd2,
        ACT_FRAME_DONE   = 3'd3,
        ACT_NO_RESPONSE  = 3'd4,
        ACT_RESPONSE     = 3'd5,
        ACT_PARITY_ERROR = 3'd6,
        ACT_SYNC_MISSING = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        PS_IDLE  = 3'd0,
        PS_BREAK = 3'd1,
        PS_SYNC  = 3'd2,
        PS_ID    = 3'd3,
        PS_DATA  = 3'd4
    } t_parse_state;

    typedef struct packed {
        logic [3:0]  sync_max;
        logic [15:0] sync_window;
        logic [15:0] break_len;
        logic        master_ready;
        logic        slave_ready;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  rx_byte;
        logic [31:0] now_us;
    } t_item;

    typedef struct packed {
        logic        last;
        logic [31:0] latency_us;
        logic [4:0]  frame_bytes;
        logic [7:0]  frame_id;
        logic [15:0] break_len_us;
        logic [7:0]  tx_byte;
        logic [2:0]  action;
    } t_result;

endpackage

// File: rtl/lin_header_regenerating_repeater.sv
// ----------------------------------------------------------------------------
// lin_header_regenerating_repeater
// LIN repeater: parses master-side headers, regenerates them on the slave
// side, forwards data bytes and reports frame and response events.
// ----------------------------------------------------------------------------
// An item passes through the input register, then the result queue, whose
// head is the first result beat; a busy queue holds it in the input register.
// Throughput: one item per cycle while each item yields at most one result and
// the output is ready; results (at most three per item) leave one beat at a time.
// Reset is synchronous and active low; it clears parser state, queue count
// and loads the configuration reset values. No clearing pass is needed.
// ----------------------------------------------------------------------------
module lin_header_regenerating_repeater
    import lhr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // rx_byte[7:0], now_us[39:8]
    input  logic [2:0]  i_s_axis_tuser,  // command[2:0]
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,  // tx_byte[7:0], break_len_us[23:8],
                                         // frame_id[31:24], frame_bytes[36:32],
                                         // latency_us[68:37], zero[71:69]
    output logic [2:0]  o_m_axis_tuser,  // action[2:0]
    output logic        o_m_axis_tlast,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg          r_cfg;
    t_item         r_in;
    logic          r_in_valid;
    logic          s_accept;
    logic          commit;
    logic          can_load;
    logic          cfg_write;
    t_reg_index    reg_idx;
    logic [1:0]    res_n;
    t_result [2:0] res_set;
    t_result       out_res;

    assign pready    = 1'b1;
    assign reg_idx   = t_reg_index'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_max     <= RST_SYNC_MAX;
            r_cfg.sync_window  <= RST_SYNC_WIN;
            r_cfg.break_len    <= RST_BREAK_LEN;
            r_cfg.master_ready <= 1'b0;
            r_cfg.slave_ready  <= 1'b0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_SYNC_MAX:     r_cfg.sync_max     <= pwdata[3:0];
                REG_SYNC_WINDOW:  r_cfg.sync_window  <= pwdata[15:0];
                REG_BREAK_LEN:    r_cfg.break_len    <= pwdata[15:0];
                REG_MASTER_READY: r_cfg.master_ready <= pwdata[0];
                REG_SLAVE_READY:  r_cfg.slave_ready  <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SYNC_MAX:     prdata = {28'd0, r_cfg.sync_max};
            REG_SYNC_WINDOW:  prdata = {16'd0, r_cfg.sync_window};
            REG_BREAK_LEN:    prdata = {16'd0, r_cfg.break_len};
            REG_MASTER_READY: prdata = {31'd0, r_cfg.master_ready};
            REG_SLAVE_READY:  prdata = {31'd0, r_cfg.slave_ready};
            default:          prdata = '0;
        endcase
    end

    // The input register frees up in the same cycle its item commits.
    assign commit          = r_in_valid && can_load;
    assign o_s_axis_tready = !r_in_valid || commit;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (commit) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in.command <= i_s_axis_tuser;
            r_in.rx_byte <= i_s_axis_tdata[7:0];
            r_in.now_us  <= i_s_axis_tdata[39:8];
        end
    end

    lhr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .i_commit (commit),
        .o_res_n  (res_n),
        .o_res    (res_set)
    );

    lhr_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (commit),
        .i_n        (res_n),
        .i_res      (res_set),
        .o_can_load (can_load),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_res      (out_res)
    );

    assign o_m_axis_tdata = {3'd0, out_res.latency_us, out_res.frame_bytes,
                             out_res.frame_id, out_res.break_len_us, out_res.tx_byte};
    assign o_m_axis_tuser = out_res.action;
    assign o_m_axis_tlast = out_res.last;

endmodule

// File: rtl/lhr_parser.sv
// ----------------------------------------------------------------------------
// lhr_parser
// Header parser state and the result set produced by one item.
// ----------------------------------------------------------------------------
module lhr_parser
    import lhr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  t_item               i_item,
    input  logic                i_commit,
    output logic [1:0]          o_res_n,
    output t_result [2:0]       o_res
);

    t_parse_state r_state, n_state;
    logic [4:0]   r_frame_count, n_frame_count;
    logic [7:0]   r_current_id, n_current_id;
    logic [31:0]  r_break_time, n_break_time;
    logic [3:0]   r_stray_count, n_stray_count;
    logic         r_awaiting, n_awaiting;
    logic         r_resp_seen, n_resp_seen;
    logic [7:0]   r_resp_id, n_resp_id;
    logic [31:0]  r_header_time, n_header_time;

    logic [7:0]  rx;
    logic [31:0] brk_elapsed;
    logic [3:0]  stray_inc;
    logic        stray_ok;
    logic        pid_good;
    logic        p0, p1;
    logic        master_off;
    logic        frame_done;
    logic        resp_missing;
    logic [1:0]  res_n;
    logic [1:0]  last_idx;

    function automatic t_result mk_result(input t_action act, input logic [7:0] txb,
                                          input logic [15:0] blen, input logic [7:0] fid,
                                          input logic [4:0] fbytes, input logic [31:0] lat);
        t_result r;
        r.action       = act;
        r.tx_byte      = txb;
        r.break_len_us = blen;
        r.frame_id     = fid;
        r.frame_bytes  = fbytes;
        r.latency_us   = lat;
        r.last         = 1'b0;
        return r;
    endfunction

    assign rx          = i_item.rx_byte;
    assign brk_elapsed = i_item.now_us - r_break_time;
    assign stray_inc   = (r_stray_count < STRAY_SAT) ? r_stray_count + 4'd1 : r_stray_count;
    assign stray_ok    = (stray_inc <= i_cfg.sync_max)
                      && (brk_elapsed <= {16'd0, i_cfg.sync_window});
    assign p0          = rx[0] ^ rx[1] ^ rx[2] ^ rx[4];
    assign p1          = ~(rx[1] ^ rx[3] ^ rx[4] ^ rx[5]);
    assign pid_good    = (rx[6] == p0) && (rx[7] == p1);
    assign master_off  = (i_item.command <= CMD_FRAME_END) && !i_cfg.master_ready;
    assign frame_done  = (r_state == PS_DATA) && (r_frame_count > HEADER_BYTES);
    assign resp_missing = r_awaiting && !r_resp_seen;

    // Next state of the parser.
    always_comb begin
        n_state       = r_state;
        n_frame_count = r_frame_count;
        n_current_id  = r_current_id;
        n_break_time  = r_break_time;
        n_stray_count = r_stray_count;
        n_awaiting    = r_awaiting;
        n_resp_seen   = r_resp_seen;
        n_resp_id     = r_resp_id;
        n_header_time = r_header_time;
        if (master_off) begin
            n_state       = PS_IDLE;
            n_frame_count = '0;
        end else begin
            case (i_item.command)
                CMD_MASTER_BYTE: begin
                    case (r_state)
                        PS_BREAK: begin
                            if (rx == SYNC_BYTE) begin
                                n_state = PS_SYNC;
                            end else if (rx != ZERO_BYTE) begin
                                n_stray_count = stray_inc;
                                if (!stray_ok) begin
                                    n_state = PS_IDLE;
                                end
                            end
                        end
                        PS_SYNC: begin
                            n_current_id = rx;
                            if (!pid_good) begin
                                n_state = PS_IDLE;
                            end else begin
                                n_frame_count = HEADER_BYTES;
                                n_awaiting    = 1'b1;
                                n_resp_seen   = 1'b0;
                                n_resp_id     = rx;
                                n_header_time = i_item.now_us;
                                n_state       = PS_ID;
                            end
                        end
                        PS_ID, PS_DATA: begin
                            if (r_frame_count < FRAME_LIMIT) begin
                                n_frame_count = r_frame_count + 5'd1;
                            end
                            n_state = PS_DATA;
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_MASTER_BREAK: begin
                    if (resp_missing) begin
                        n_awaiting = 1'b0;
                    end
                    n_state       = PS_BREAK;
                    n_frame_count = '0;
                    n_break_time  = i_item.now_us;
                    n_stray_count = '0;
                end
                CMD_OVERFLOW: begin
                    n_state       = PS_IDLE;
                    n_frame_count = '0;
                end
                CMD_FRAME_END: begin
                    if (frame_done) begin
                        n_state = PS_IDLE;
                    end
                end
                CMD_SLAVE_BYTE: begin
                    if (i_cfg.slave_ready && resp_missing) begin
                        n_resp_seen = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Results caused by the item in the input register.
    always_comb begin
        res_n = 2'd0;
        o_res = '0;
        if (!master_off) begin
            case (i_item.command)
                CMD_MASTER_BYTE: begin
                    case (r_state)
                        PS_BREAK: begin
                            if (rx != SYNC_BYTE && rx != ZERO_BYTE && !stray_ok) begin
                                o_res[0] = mk_result(ACT_SYNC_MISSING, '0, '0, '0, '0, '0);
                                res_n    = 2'd1;
                            end
                        end
                        PS_SYNC: begin
                            if (!pid_good) begin
                                o_res[0] = mk_result(ACT_PARITY_ERROR, '0, '0, rx, '0, '0);
                                res_n    = 2'd1;
                            end else begin
                                o_res[0] = mk_result(ACT_SEND_BREAK, '0, i_cfg.break_len,
                                                     '0, '0, '0);
                                o_res[1] = mk_result(ACT_TO_SLAVE, SYNC_BYTE, '0, '0, '0, '0);
                                o_res[2] = mk_result(ACT_TO_SLAVE, rx, '0, '0, '0, '0);
                                res_n    = 2'd3;
                            end
                        end
                        PS_ID, PS_DATA: begin
                            o_res[0] = mk_result(ACT_TO_SLAVE, rx, '0, '0, '0, '0);
                            res_n    = 2'd1;
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_MASTER_BREAK: begin
                    if (frame_done) begin
                        o_res[0] = mk_result(ACT_FRAME_DONE, '0, '0, r_current_id,
                                             r_frame_count, '0);
                        res_n    = 2'd1;
                    end
                    if (resp_missing) begin
                        o_res[res_n] = mk_result(ACT_NO_RESPONSE, '0, '0, r_resp_id, '0, '0);
                        res_n        = res_n + 2'd1;
                    end
                end
                CMD_FRAME_END: begin
                    if (frame_done) begin
                        o_res[0] = mk_result(ACT_FRAME_DONE, '0, '0, r_current_id,
                                             r_frame_count, '0);
                        res_n    = 2'd1;
                    end
                end
                CMD_SLAVE_BYTE: begin
                    if (i_cfg.slave_ready) begin
                        if (resp_missing) begin
                            o_res[0] = mk_result(ACT_RESPONSE, '0, '0, r_resp_id, '0,
                                                 i_item.now_us - r_header_time);
                            o_res[1] = mk_result(ACT_TO_MASTER, rx, '0, '0, '0, '0);
                            res_n    = 2'd2;
                        end else begin
                            o_res[0] = mk_result(ACT_TO_MASTER, rx, '0, '0, '0, '0);
                            res_n    = 2'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        last_idx = res_n - 2'd1;
        if (res_n != 2'd0) begin
            o_res[last_idx].last = 1'b1;
        end
    end

    assign o_res_n = res_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= PS_IDLE;
            r_frame_count <= '0;
            r_current_id  <= '0;
            r_break_time  <= '0;
            r_stray_count <= '0;
            r_awaiting    <= 1'b0;
            r_resp_seen   <= 1'b0;
            r_resp_id     <= '0;
            r_header_time <= '0;
        end else if (i_commit) begin
            r_state       <= n_state;
            r_frame_count <= n_frame_count;
            r_current_id  <= n_current_id;
            r_break_time  <= n_break_time;
            r_stray_count <= n_stray_count;
            r_awaiting    <= n_awaiting;
            r_resp_seen   <= n_resp_seen;
            r_resp_id     <= n_resp_id;
            r_header_time <= n_header_time;
        end
    end

`ifndef SYNTHESIS
    a_seen_implies_awaiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_resp_seen |-> r_awaiting)
        else $error("response marked seen without a pending header");

    a_frame_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_count <= FRAME_LIMIT)
        else $error("frame byte count beyond buffer limit");

    a_id_state_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == PS_ID) |-> (r_frame_count == HEADER_BYTES && r_awaiting))
        else $error("header sent but frame count or response flag wrong");
`endif

endmodule

// File: rtl/lhr_out_queue.sv
// ----------------------------------------------------------------------------
// lhr_out_queue
// Holds the up to three results of one item and sends them one beat at a time.
// ----------------------------------------------------------------------------
module lhr_out_queue
    import lhr_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic [1:0]     i_n,
    input  t_result [2:0]  i_res,
    output logic           o_can_load,
    output logic           o_valid,
    input  logic           i_ready,
    output t_result        o_res
);

    t_result [2:0] r_slot, n_slot;
    logic [1:0]    r_cnt, n_cnt;
    logic          pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign pop        = o_valid && i_ready;
    // A new set may enter once the last beat of the current one leaves.
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);
    assign o_res      = r_slot[0];

    always_comb begin
        n_slot = r_slot;
        n_cnt  = r_cnt;
        if (i_load) begin
            n_slot = i_res;
            n_cnt  = i_n;
        end else if (pop) begin
            n_slot[0] = r_slot[1];
            n_slot[1] = r_slot[2];
            n_cnt     = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

`ifndef SYNTHESIS
    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_slot[0].last == (r_cnt == 2'd1)))
        else $error("last flag does not match the final queued beat");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_cnt == $past(i_n)))
        else $error("queue count differs from the loaded result count");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_n != 2'd0) |-> (r_cnt == 2'd0 || pop))
        else $error("result set loaded over pending beats");
`endif

endmodule
